// ----- rtl/stereo_predictive_residual_coder_assert.svh -----
// Assertion macros shared by the coder RTL.
`ifndef STEREO_PREDICTIVE_RESIDUAL_CODER_ASSERT_SVH
`define STEREO_PREDICTIVE_RESIDUAL_CODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spr assertion failed");

// Next-cycle implication, disabled during reset.
`define SPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spr assertion failed");

`endif

// ----- rtl/spr_pkg.sv -----
`timescale 1ns / 1ps

package spr_pkg;

  // Sample and state widths
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 28;
  localparam int CNT_W     = 12;
  localparam int M_W       = 16;
  localparam int QB_W      = 4;
  localparam int CFG_W     = 16;

  // Fixed-point log2: integer part, Q16 fraction, Q1.30 mantissa
  localparam int LOG_INT_W = 5;
  localparam int FRAC_W    = 16;
  localparam int LOG_W     = LOG_INT_W + FRAC_W;
  localparam int NORM_W    = 31;
  localparam int SQ_CNT_W  = $clog2(FRAC_W);

  // Ceiling divide of 2^16 by the log difference
  localparam int DIV_W     = LOG_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Register reset values
  localparam logic             RST_LOSSLESS  = 1'b1;
  localparam logic [QB_W-1:0]  RST_QUANT     = '0;
  localparam logic [M_W-1:0]   RST_INITIAL_M = 16'd4;
  localparam logic [CNT_W-1:0] RST_WINDOW    = 12'd1000;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [M_W-1:0]   M_MAX   = '1;
  localparam logic [M_W:0]     M_BIAS  = 17'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LOSSLESS_MODE  = 2'd0,
    REG_QUANT_BITS     = 2'd1,
    REG_INITIAL_M      = 2'd2,
    REG_WINDOW_LENGTH  = 2'd3
  } cfg_reg_t;

  // Per-lane controls from the sequencer
  typedef struct packed {
    logic load;
    logic pred;
    logic acc;
    logic est_start;
  } lane_ctl_t;

  // Per-lane status toward the merge stage
  typedef struct packed {
    logic           busy;
    logic [M_W-1:0] m;
  } lane_sts_t;

endpackage

// ----- rtl/spr_mest.sv -----
`timescale 1ns / 1ps

// Golomb parameter estimate for one channel:
// m = ceil(2^16 / (L(n+s) - L(s))), with L a Q16 log2 computed by repeated squaring.
module spr_mest (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spr_pkg::CNT_W-1:0]  n,
  input  logic [spr_pkg::SUM_W-1:0]  s,
  output logic                       busy,
  output logic [spr_pkg::M_W-1:0]    m
);

  typedef enum logic [1:0] {ST_IDLE, ST_NORM, ST_SQR, ST_DIV} state_t;

  state_t                              state;
  logic                                phase;
  logic [spr_pkg::NORM_W-1:0]          y;
  logic [spr_pkg::LOG_INT_W-1:0]       k;
  logic [spr_pkg::FRAC_W-1:0]          frac;
  logic [spr_pkg::SQ_CNT_W-1:0]        sq_cnt;
  logic [spr_pkg::LOG_W-1:0]           log_hi;
  logic [spr_pkg::SUM_W-1:0]           s_hold;
  logic [spr_pkg::LOG_W-1:0]           divisor;
  logic [spr_pkg::DIV_W-1:0]           rem;
  logic [spr_pkg::DIV_W-1:0]           quo;
  logic [spr_pkg::DIV_CNT_W-1:0]       div_cnt;

  logic [spr_pkg::SUM_W:0]             n_plus_s;
  logic [2*spr_pkg::NORM_W-1:0]        prod;
  logic [spr_pkg::NORM_W:0]            sq;
  logic [spr_pkg::FRAC_W-1:0]          frac_next;
  logic [spr_pkg::LOG_W-1:0]           log_now;
  logic [spr_pkg::LOG_W-1:0]           log_diff;
  logic [spr_pkg::DIV_W-1:0]           dividend;
  logic [spr_pkg::DIV_W-1:0]           rem_shift;
  logic                                rem_ge;
  logic [spr_pkg::DIV_W-1:0]           rem_next;
  logic [spr_pkg::DIV_W-1:0]           quo_next;

  assign busy = (state != ST_IDLE);

  // Squaring step of the log: Q1.30 squared, taken as Q2.30
  assign n_plus_s  = {1'b0, s} + (spr_pkg::SUM_W+1)'(n);
  assign prod      = y * y;
  assign sq        = prod[2*spr_pkg::NORM_W-1 : spr_pkg::NORM_W-1];
  assign frac_next = {frac[spr_pkg::FRAC_W-2:0], sq[spr_pkg::NORM_W]};
  assign log_now   = {k, frac_next};
  assign log_diff  = log_hi - log_now;
  assign dividend  = spr_pkg::DIV_W'(1 << spr_pkg::FRAC_W)
                     + spr_pkg::DIV_W'(log_diff) - spr_pkg::DIV_W'(1);

  // Restoring divide, one quotient bit per cycle
  assign rem_shift = {rem[spr_pkg::DIV_W-2:0], quo[spr_pkg::DIV_W-1]};
  assign rem_ge    = (rem_shift >= spr_pkg::DIV_W'(divisor));
  assign rem_next  = rem_ge ? (rem_shift - spr_pkg::DIV_W'(divisor)) : rem_shift;
  assign quo_next  = {quo[spr_pkg::DIV_W-2:0], rem_ge};

  // Sequence: normalize, square 16 times, repeat for s, then divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (s == '0) begin
              m <= '0;
            end else begin
              s_hold <= s;
              y      <= spr_pkg::NORM_W'(n_plus_s);
              k      <= spr_pkg::LOG_INT_W'(spr_pkg::NORM_W - 1);
              phase  <= 1'b0;
              state  <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          if (y[spr_pkg::NORM_W-1]) begin
            sq_cnt <= '0;
            frac   <= '0;
            state  <= ST_SQR;
          end else if (y[spr_pkg::NORM_W-1 -: 4] == 4'd0) begin
            y <= y << 4;
            k <= k - spr_pkg::LOG_INT_W'(4);
          end else begin
            y <= y << 1;
            k <= k - spr_pkg::LOG_INT_W'(1);
          end
        end
        ST_SQR: begin
          frac   <= frac_next;
          sq_cnt <= sq_cnt + spr_pkg::SQ_CNT_W'(1);
          if (sq_cnt != spr_pkg::SQ_CNT_W'(spr_pkg::FRAC_W - 1)) begin
            y <= sq[spr_pkg::NORM_W] ? sq[spr_pkg::NORM_W:1] : sq[spr_pkg::NORM_W-1:0];
          end else if (!phase) begin
            // hold L(n+s), restart on s
            log_hi <= log_now;
            phase  <= 1'b1;
            y      <= spr_pkg::NORM_W'(s_hold);
            k      <= spr_pkg::LOG_INT_W'(spr_pkg::NORM_W - 1);
            state  <= ST_NORM;
          end else if (log_diff == '0) begin
            m     <= spr_pkg::M_MAX;
            state <= ST_IDLE;
          end else begin
            divisor <= log_diff;
            quo     <= dividend;
            rem     <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem     <= rem_next;
          quo     <= quo_next;
          div_cnt <= div_cnt + spr_pkg::DIV_CNT_W'(1);
          if (div_cnt == spr_pkg::DIV_CNT_W'(spr_pkg::DIV_W - 1)) begin
            // saturate to the field width
            m     <= (|quo_next[spr_pkg::DIV_W-1:spr_pkg::M_W]) ? spr_pkg::M_MAX
                                                               : quo_next[spr_pkg::M_W-1:0];
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/spr_lane.sv -----
`timescale 1ns / 1ps

// One channel: predictor, history, zigzag accumulator and parameter estimate.
module spr_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  spr_pkg::lane_ctl_t            ctl,
  input  logic                          lossless,
  input  logic [spr_pkg::QB_W-1:0]      qbits,
  input  logic [spr_pkg::SAMPLE_W-1:0]  sample,
  input  logic [spr_pkg::CNT_W-1:0]     n,
  output logic [spr_pkg::SAMPLE_W-1:0]  residual,
  output spr_pkg::lane_sts_t            sts
);

  logic [spr_pkg::SAMPLE_W-1:0] x;
  logic [spr_pkg::SAMPLE_W-1:0] h0;
  logic [spr_pkg::SAMPLE_W-1:0] h1;
  logic [spr_pkg::SAMPLE_W-1:0] h2;
  logic [spr_pkg::SUM_W-1:0]    sum;

  logic [spr_pkg::SAMPLE_W-1:0] pred3;
  logic [spr_pkg::SAMPLE_W-1:0] diff3;
  logic [spr_pkg::SAMPLE_W-1:0] diff1;
  logic signed [spr_pkg::SAMPLE_W-1:0] dq;
  logic [spr_pkg::SAMPLE_W-1:0] dq_up;
  logic [spr_pkg::SAMPLE_W-1:0] res_next;
  logic [spr_pkg::SAMPLE_W-1:0] recon;
  logic [spr_pkg::SAMPLE_W-1:0] mapped;
  logic [spr_pkg::SUM_W:0]      sum_wide;
  logic                         est_busy;
  logic [spr_pkg::M_W-1:0]      est_m;

  // Third-order and first-order predictions, all modulo the sample width
  assign pred3    = {h0[spr_pkg::SAMPLE_W-2:0], 1'b0} + h0
                    - ({h1[spr_pkg::SAMPLE_W-2:0], 1'b0} + h1) + h2;
  assign diff3    = x - pred3;
  assign diff1    = x - h0;
  assign dq       = $signed(diff1) >>> qbits;
  assign dq_up    = dq << qbits;
  assign res_next = lossless ? diff3 : dq;
  assign recon    = lossless ? x : (h0 + dq_up);

  // Zigzag map and saturating accumulate
  assign mapped   = {residual[spr_pkg::SAMPLE_W-2:0], 1'b0}
                    ^ {spr_pkg::SAMPLE_W{residual[spr_pkg::SAMPLE_W-1]}};
  assign sum_wide = {1'b0, sum} + (spr_pkg::SUM_W+1)'(mapped);

  always_ff @(posedge clk) begin
    if (rst) begin
      h0  <= '0;
      h1  <= '0;
      h2  <= '0;
      sum <= '0;
    end else begin
      if (ctl.pred) begin
        h2 <= h1;
        h1 <= h0;
        h0 <= recon;
      end
      if (ctl.acc) begin
        sum <= sum_wide[spr_pkg::SUM_W] ? spr_pkg::SUM_MAX : sum_wide[spr_pkg::SUM_W-1:0];
      end else if (ctl.est_start) begin
        sum <= '0;
      end
    end
  end

  // Sample and residual registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= sample;
    end
    if (ctl.pred) begin
      residual <= res_next;
    end
  end

  spr_mest u_mest (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.est_start),
    .n     (n),
    .s     (sum),
    .busy  (est_busy),
    .m     (est_m)
  );

  assign sts.busy = est_busy;
  assign sts.m    = est_m;

endmodule

// ----- rtl/stereo_predictive_residual_coder.sv -----
// Sequence: an accepted frame passes the predict, accumulate and output steps, the last
// waiting while a held result is stalled; a frame that closes a window also passes the close,
// estimate and merge steps, estimate waiting on the per-lane estimators (two 16-step squaring
// log2 runs and a 22-step bit-serial divide). One frame in flight: in_stall holds off the next.
// Reset (rst, synchronous): clears histories, sums, window count and output valid;
// registers return to lossless, quant 0, m 4, window 1000.
`timescale 1ns / 1ps
`include "stereo_predictive_residual_coder_assert.svh"

module stereo_predictive_residual_coder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spr_pkg::SAMPLE_W-1:0]  left_sample,
  input  logic [spr_pkg::SAMPLE_W-1:0]  right_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spr_pkg::SAMPLE_W-1:0]  left_residual,
  output logic [spr_pkg::SAMPLE_W-1:0]  right_residual,
  output logic [spr_pkg::M_W-1:0]       golomb_m,
  output logic                          m_updated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [spr_pkg::CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRED, ST_ACC, ST_CLOSE, ST_EST, ST_MERGE, ST_OUT
  } state_t;

  state_t                       state;
  logic                         lossless_mode;
  logic [spr_pkg::QB_W-1:0]     quant_bits;
  logic [spr_pkg::CNT_W-1:0]    window_length;
  logic [spr_pkg::CNT_W-1:0]    window_count;
  logic [spr_pkg::M_W-1:0]      current_m;
  logic [spr_pkg::M_W-1:0]      used_m;
  logic                         upd;

  spr_pkg::lane_ctl_t           ctl;
  spr_pkg::lane_sts_t           lsts;
  spr_pkg::lane_sts_t           rsts;
  logic [spr_pkg::SAMPLE_W-1:0] lres;
  logic [spr_pkg::SAMPLE_W-1:0] rres;

  logic [spr_pkg::CNT_W-1:0]    wl_eff;
  logic [spr_pkg::CNT_W-1:0]    count_inc;
  logic [spr_pkg::M_W:0]        m_sum;
  logic [spr_pkg::M_W:0]        m_new_wide;
  logic [spr_pkg::M_W-1:0]      m_new;
  logic                         out_free;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // Lane controls
  assign ctl.load      = (state == ST_IDLE) && in_valid;
  assign ctl.pred      = (state == ST_PRED);
  assign ctl.acc       = (state == ST_ACC);
  assign ctl.est_start = (state == ST_CLOSE);

  // Window bookkeeping
  assign wl_eff    = (window_length == '0) ? spr_pkg::CNT_W'(1) : window_length;
  assign count_inc = window_count + spr_pkg::CNT_W'(1);

  // Merge the lane estimates: average plus bias, saturated
  assign m_sum      = {1'b0, lsts.m} + {1'b0, rsts.m};
  assign m_new_wide = {1'b0, m_sum[spr_pkg::M_W:1]} + spr_pkg::M_BIAS;
  assign m_new      = m_new_wide[spr_pkg::M_W] ? spr_pkg::M_MAX : m_new_wide[spr_pkg::M_W-1:0];

  spr_lane u_lane_left (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .lossless (lossless_mode),
    .qbits    (quant_bits),
    .sample   (left_sample),
    .n        (window_count),
    .residual (lres),
    .sts      (lsts)
  );

  spr_lane u_lane_right (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .lossless (lossless_mode),
    .qbits    (quant_bits),
    .sample   (right_sample),
    .n        (window_count),
    .residual (rres),
    .sts      (rsts)
  );

  // Sequencer, configuration registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      lossless_mode    <= spr_pkg::RST_LOSSLESS;
      quant_bits       <= spr_pkg::RST_QUANT;
      window_length    <= spr_pkg::RST_WINDOW;
      window_count     <= '0;
      current_m        <= spr_pkg::RST_INITIAL_M;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (spr_pkg::cfg_reg_t'(cfg_index))
          spr_pkg::REG_LOSSLESS_MODE: lossless_mode <= cfg_data[0];
          spr_pkg::REG_QUANT_BITS:    quant_bits    <= cfg_data[spr_pkg::QB_W-1:0];
          spr_pkg::REG_INITIAL_M:     current_m     <= cfg_data[spr_pkg::M_W-1:0];
          spr_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[spr_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      // drop the output once taken; the output step reloads it itself
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_PRED;
          end
        end
        ST_PRED: state <= ST_ACC;
        ST_ACC: begin
          window_count <= count_inc;
          used_m       <= current_m;
          upd          <= 1'b0;
          state        <= (count_inc >= wl_eff) ? ST_CLOSE : ST_OUT;
        end
        ST_CLOSE: begin
          window_count <= '0;
          state        <= ST_EST;
        end
        ST_EST: begin
          if (!lsts.busy && !rsts.busy) begin
            state <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          upd       <= (m_new != current_m);
          current_m <= m_new;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            left_residual  <= lres;
            right_residual <= rres;
            golomb_m       <= used_m;
            m_updated      <= upd;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Estimators must be quiet whenever a new transaction can enter
  `SPR_ASSERT_NOW(a_est_quiet_idle, clk, rst, state == ST_IDLE, !lsts.busy && !rsts.busy)
  // An accepted transaction starts the predictor step next
  `SPR_ASSERT_NEXT(a_accept_to_pred, clk, rst, in_valid && !in_stall, state == ST_PRED)
  // A result appears only from the output step
  `SPR_ASSERT_NOW(a_out_from_out_state, clk, rst, $rose(out_valid), $past(state) == ST_OUT)

endmodule
